### rtl/sdsh_pkg.sv
// sdsh_pkg: shared widths, codes and reset constants for the step detector
// with speed hold; no dependencies, used by the top level and the testbench
`default_nettype none

package sdsh_pkg;

    // field widths fixed by the interface
    localparam int MV_W   = 12;
    localparam int RPM_W  = 19;
    localparam int ACT_W  = 2;

    // default window depths
    localparam int VOLTAGE_WINDOW_DEF = 20;
    localparam int SPEED_WINDOW_DEF   = 20;

    // threshold after reset, millivolts
    localparam logic [MV_W-1:0] THRESH_RESET = 12'd3000;

    // result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_HOLD    = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

endpackage

`default_nettype wire

### rtl/sdsh_cell.sv
// sdsh_cell: one sample slot of a window line
// hands its sample to the next cell on every shift; no package use
`default_nettype none

module sdsh_cell #(
    parameter int W = 12
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_shift,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_data;

    // slot content, cleared at reset so early means include zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/sdsh_window.sv
// sdsh_window: sliding window built as a line of sdsh_cell with a running sum
// depends on sdsh_cell
`default_nettype none

module sdsh_window #(
    parameter int W         = 12,
    parameter int DEPTH     = 20,
    parameter bit IS_SIGNED = 1'b0,
    parameter int SUM_W     = W + $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire logic [W-1:0]     i_sample,
    output logic      [SUM_W-1:0] o_sum
);

    localparam int EXT_W = SUM_W - W;

    logic [W-1:0]     w_tap [DEPTH];
    logic [SUM_W-1:0] w_new_ext;
    logic [SUM_W-1:0] w_old_ext;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    // line of cells, newest at the head, oldest at the tail
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            sdsh_cell #(.W(W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_data  (i_sample),
                .o_data  (w_tap[k])
            );
        end else begin : g_body
            sdsh_cell #(.W(W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_data  (w_tap[k-1]),
                .o_data  (w_tap[k])
            );
        end
    end

    // extend incoming and outgoing samples to sum width
    assign w_new_ext = {{EXT_W{IS_SIGNED & i_sample[W-1]}}, i_sample};
    assign w_old_ext = {{EXT_W{IS_SIGNED & w_tap[DEPTH-1][W-1]}}, w_tap[DEPTH-1]};

    // running sum: drop the oldest, add the newest
    always_comb begin
        n_sum = r_sum - w_old_ext + w_new_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

### rtl/step_detect_speed_hold_unit.sv
// step_detect_speed_hold_unit: top level of the pedal step detector with speed hold
// depends on sdsh_pkg and sdsh_window
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one voltage sample and one
//   speed sample per transfer. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result per input transfer, in order.
//   Threshold is written through i_cfg_we / i_cfg_data while the block is idle.
// Pipeline: a result moves through three registered stages (window update,
//   compare and reciprocal multiply, quotient correction into the output
//   register), each passing on as soon as the next is free; one transfer
//   per cycle is taken while o_in_stall is low.
// Reset: synchronous, active low; clears both windows, both running sums,
//   the pressed flag and all stage valids, and loads the default threshold.
// Stall: a stalled result holds at the output; stages behind it keep filling
//   until full, then o_in_stall rises in the same cycle.
`default_nettype none

module step_detect_speed_hold_unit #(
    parameter int VOLTAGE_WINDOW = sdsh_pkg::VOLTAGE_WINDOW_DEF,
    parameter int SPEED_WINDOW   = sdsh_pkg::SPEED_WINDOW_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic        [sdsh_pkg::MV_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic        [sdsh_pkg::MV_W-1:0]   i_sensor_mv,
    input  wire logic signed [sdsh_pkg::RPM_W-1:0]  i_motor_rpm,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic             [sdsh_pkg::ACT_W-1:0]  o_action,
    output logic signed      [sdsh_pkg::RPM_W-1:0]  o_speed_target,
    output logic                                    o_pressed
);

    localparam int MV_W   = sdsh_pkg::MV_W;
    localparam int RPM_W  = sdsh_pkg::RPM_W;
    localparam int VSUM_W = MV_W + $clog2(VOLTAGE_WINDOW);
    localparam int SSUM_W = RPM_W + $clog2(SPEED_WINDOW);
    localparam int MAG_W  = SSUM_W;
    localparam int SHIFT_K = MAG_W + $clog2(SPEED_WINDOW);
    localparam int PROD_W = MAG_W + SHIFT_K;
    localparam int DIV_W  = $clog2(SPEED_WINDOW + 1);
    localparam int QD_W   = MAG_W + DIV_W;

    localparam logic [63:0]        RECIP64 = (64'd1 << SHIFT_K) / 64'(SPEED_WINDOW);
    localparam logic [SHIFT_K-1:0] RECIP   = RECIP64[SHIFT_K-1:0];
    localparam logic [DIV_W-1:0]   DIV_C   = DIV_W'(SPEED_WINDOW);
    localparam logic [VSUM_W-1:0]  THR_SCALED_RESET =
        VSUM_W'(int'(sdsh_pkg::THRESH_RESET) * VOLTAGE_WINDOW);

    // handshake
    logic w_accept;
    logic w_s1_go;
    logic w_s2_go;
    logic w_s1_ready;
    logic w_s2_ready;
    logic w_s3_ready;

    // state and stage registers
    logic [VSUM_W-1:0]        r_thr_scaled;
    logic                     r_was_pressed;
    logic                     r_s1_v;
    logic                     r_s2_v;
    logic                     r_s3_v;
    logic [VSUM_W-1:0]        w_vsum;
    logic signed [SSUM_W-1:0] w_ssum;

    sdsh_pkg::t_action        r_s2_act;
    logic                     r_s2_pressed;
    logic                     r_s2_neg;
    logic [MAG_W-1:0]         r_s2_mag;
    logic [PROD_W-1:0]        r_s2_prod;

    sdsh_pkg::t_action        r_s3_act;
    logic                     r_s3_pressed;
    logic [RPM_W-1:0]         r_s3_target;

    // stage two next values
    sdsh_pkg::t_action        n_s2_act;
    logic                     n_now_pressed;
    logic                     n_s2_neg;
    logic [MAG_W-1:0]         n_s2_mag;
    logic [PROD_W-1:0]        n_s2_prod;

    // stage three next values
    logic [MAG_W-1:0]         w_q_est;
    logic [QD_W-1:0]          w_qd;
    logic [QD_W-1:0]          w_rem;
    logic [MAG_W-1:0]         w_q;
    logic [MAG_W-1:0]         w_sq;
    logic [RPM_W-1:0]         n_s3_target;

    // stage readiness, back to front
    assign w_s3_ready = !r_s3_v || !i_out_stall;
    assign w_s2_ready = !r_s2_v || w_s3_ready;
    assign w_s1_ready = !r_s1_v || w_s2_ready;
    assign w_accept   = i_in_valid && w_s1_ready;
    assign w_s1_go    = r_s1_v && w_s2_ready;
    assign w_s2_go    = r_s2_v && w_s3_ready;
    assign o_in_stall = !w_s1_ready;

    // threshold kept pre-scaled by the window depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_scaled <= THR_SCALED_RESET;
        end else if (i_cfg_we) begin
            r_thr_scaled <= VSUM_W'(VSUM_W'(i_cfg_data) * VSUM_W'(VOLTAGE_WINDOW));
        end
    end

    // stage one: both windows shift on every input transfer
    sdsh_window #(
        .W         (MV_W),
        .DEPTH     (VOLTAGE_WINDOW),
        .IS_SIGNED (1'b0),
        .SUM_W     (VSUM_W)
    ) u_volt_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept),
        .i_sample (i_sensor_mv),
        .o_sum    (w_vsum)
    );

    sdsh_window #(
        .W         (RPM_W),
        .DEPTH     (SPEED_WINDOW),
        .IS_SIGNED (1'b1),
        .SUM_W     (SSUM_W)
    ) u_speed_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept),
        .i_sample (i_motor_rpm),
        .o_sum    (w_ssum)
    );

    // stage two: threshold compare, edge detect, magnitude times reciprocal
    always_comb begin
        n_now_pressed = w_vsum < r_thr_scaled;
        if (n_now_pressed == r_was_pressed) begin
            n_s2_act = sdsh_pkg::ACT_NONE;
        end else if (n_now_pressed) begin
            n_s2_act = sdsh_pkg::ACT_HOLD;
        end else begin
            n_s2_act = sdsh_pkg::ACT_RELEASE;
        end
        n_s2_neg  = w_ssum[SSUM_W-1];
        n_s2_mag  = n_s2_neg ? MAG_W'(-w_ssum) : MAG_W'(w_ssum);
        n_s2_prod = PROD_W'(n_s2_mag) * PROD_W'(RECIP);
    end

    // stage three: fix the estimate up by at most one, restore sign, zero the target unless hold
    always_comb begin
        w_q_est = r_s2_prod[SHIFT_K +: MAG_W];
        w_qd    = QD_W'(w_q_est) * QD_W'(DIV_C);
        w_rem   = QD_W'(r_s2_mag) - w_qd;
        w_q     = w_q_est + MAG_W'(w_rem >= QD_W'(DIV_C));
        w_sq    = r_s2_neg ? -w_q : w_q;
        if (r_s2_act == sdsh_pkg::ACT_HOLD) begin
            n_s3_target = w_sq[RPM_W-1:0];
        end else begin
            n_s3_target = '0;
        end
    end

    // stage valids and pressed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_s3_v        <= 1'b0;
            r_was_pressed <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_go) begin
                r_s2_v        <= 1'b1;
                r_was_pressed <= n_now_pressed;
            end else if (w_s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (w_s2_go) begin
                r_s3_v <= 1'b1;
            end else if (r_s3_v && !i_out_stall) begin
                r_s3_v <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_s2_act     <= n_s2_act;
            r_s2_pressed <= n_now_pressed;
            r_s2_neg     <= n_s2_neg;
            r_s2_mag     <= n_s2_mag;
            r_s2_prod    <= n_s2_prod;
        end
        if (w_s2_go) begin
            r_s3_act     <= r_s2_act;
            r_s3_pressed <= r_s2_pressed;
            r_s3_target  <= n_s3_target;
        end
    end

    // output register drives the result channel
    assign o_out_valid    = r_s3_v;
    assign o_action       = r_s3_act;
    assign o_speed_target = r_s3_target;
    assign o_pressed      = r_s3_pressed;

endmodule

`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking testbench for step_detect_speed_hold_unit
// depends on sdsh_pkg and the rtl of the block; keeps its own model of the
// averaging windows and the pressed flag and checks every result transfer
`timescale 1ns / 1ps

module tb_top;

    localparam int VOLT_WIN    = sdsh_pkg::VOLTAGE_WINDOW_DEF;
    localparam int SPEED_WIN   = sdsh_pkg::SPEED_WINDOW_DEF;
    localparam int MV_W        = sdsh_pkg::MV_W;
    localparam int RPM_W       = sdsh_pkg::RPM_W;
    localparam int ACT_W       = sdsh_pkg::ACT_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_TAIL  = 6;

    typedef struct {
        sdsh_pkg::t_action        act;
        logic signed [RPM_W-1:0]  target;
        logic                     pressed;
    } t_pedal_result;

    // dut ports
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [MV_W-1:0]           i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [MV_W-1:0]           i_sensor_mv;
    logic signed [RPM_W-1:0]   i_motor_rpm;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [ACT_W-1:0]          o_action;
    logic signed [RPM_W-1:0]   o_speed_target;
    logic                      o_pressed;

    // model state: windows, running sums, flag and threshold
    logic [MV_W-1:0]           volt_ring [VOLT_WIN];
    logic signed [RPM_W-1:0]   rpm_ring [SPEED_WIN];
    int                        volt_slot;
    int                        rpm_slot;
    logic [16:0]               volt_sum;
    logic signed [23:0]        rpm_sum;
    logic                      model_pressed;
    logic [MV_W-1:0]           press_thresh;

    t_pedal_result             pending_actions [$];
    int                        mismatch_count;
    int                        cycle_count;
    bit                        stall_on;
    bit                        idle_on;

    step_detect_speed_hold_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sensor_mv    (i_sensor_mv),
        .i_motor_rpm    (i_motor_rpm),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_speed_target (o_speed_target),
        .o_pressed      (o_pressed)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // update both windows and work out the action for one sample pair
    function automatic t_pedal_result predict_pedal_step(input logic [MV_W-1:0] mv,
                                                         input logic signed [RPM_W-1:0] rpm);
        t_pedal_result r;
        logic          now_pressed;
        volt_sum = volt_sum - volt_ring[volt_slot] + mv;
        volt_ring[volt_slot] = mv;
        volt_slot = (volt_slot == VOLT_WIN - 1) ? 0 : volt_slot + 1;
        rpm_sum = rpm_sum - rpm_ring[rpm_slot] + rpm;
        rpm_ring[rpm_slot] = rpm;
        rpm_slot = (rpm_slot == SPEED_WIN - 1) ? 0 : rpm_slot + 1;
        // mean below threshold, compared without division
        now_pressed = int'(volt_sum) < int'(press_thresh) * VOLT_WIN;
        r.act = sdsh_pkg::ACT_NONE;
        r.target = '0;
        if (now_pressed != model_pressed) begin
            model_pressed = now_pressed;
            if (now_pressed) begin
                r.act = sdsh_pkg::ACT_HOLD;
                // int division truncates toward zero
                r.target = RPM_W'(int'(rpm_sum) / SPEED_WIN);
            end else begin
                r.act = sdsh_pkg::ACT_RELEASE;
            end
        end
        r.pressed = model_pressed;
        return r;
    endfunction

    function automatic void report_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    // predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_pedal_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_actions.size() == 0) begin
                    report_mismatch("unexpected result action", -1, int'(o_action));
                end else begin
                    want = pending_actions.pop_front();
                    if (o_action !== want.act)
                        report_mismatch("action", int'(want.act), int'(o_action));
                    if (o_speed_target !== want.target)
                        report_mismatch("speed_target", int'(want.target),
                                        int'(o_speed_target));
                    if (o_pressed !== want.pressed)
                        report_mismatch("pressed", int'(want.pressed), int'(o_pressed));
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_actions.push_back(predict_pedal_step(i_sensor_mv, i_motor_rpm));
            if (i_cfg_we)
                press_thresh = i_cfg_data;
        end
    end

    // receiver backpressure: mostly short stalls, a few long ones
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else if (stall_on && $urandom_range(0, 99) < 12) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // one sample transfer, after a random gap while idling is enabled
    task automatic send_sample(input logic [MV_W-1:0] mv, input logic signed [RPM_W-1:0] rpm);
        int gap;
        int pick;
        gap = 0;
        if (idle_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)
                gap = $urandom_range(8, 40);
            else if (pick >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_sensor_mv = mv;
        i_motor_rpm = rpm;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait until every result has arrived
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_actions.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [MV_W-1:0] value);
        wait_results_done();
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // rings start at zero, so the default threshold reads as pressed at once
    task automatic test_early_ticks();
        send_sample(12'd4095, 19'sd200000);
        send_sample(12'd0, -19'sd200000);
    endtask

    // zero and full-scale thresholds, field extremes and raw rpm patterns
    task automatic test_threshold_extremes();
        write_threshold(12'd0);
        send_sample(12'd4095, 19'h40000);
        send_sample(12'd0, 19'h3FFFF);
        send_sample(12'd0, 19'sd1);
        write_threshold(12'd4095);
        send_sample(12'd0, -19'sd39);
        send_sample(12'd4095, 19'sd1);
        write_threshold(12'd1);
        send_sample(12'd0, 19'sd0);
        send_sample(12'd1, -19'sd200000);
        write_threshold(12'd2048);
        send_sample(12'd2048, -19'sd19);
        send_sample(12'd4095, 19'sd200000);
        send_sample(12'd0, -19'sd7);
    endtask

    // press and release segments with random speeds over several thresholds
    task automatic test_random_pedal();
        logic [MV_W-1:0]          th_list [6];
        int                       item_list [6];
        int                       sent;
        int                       seg_len;
        int                       kind;
        int                       mv;
        int                       rpm;
        int                       cruise;
        int                       pick;
        th_list = '{sdsh_pkg::THRESH_RESET, 12'($urandom_range(1, 4094)), 12'd4095, 12'd0,
                    12'd1, 12'($urandom_range(100, 4000))};
        item_list = '{300, 300, 150, 100, 100, 300};
        for (int p = 0; p < 6; p++) begin
            write_threshold(th_list[p]);
            // one phase runs with no idling on either side
            idle_on = (p != 1);
            stall_on = (p != 1);
            sent = 0;
            while (sent < item_list[p]) begin
                kind = $urandom_range(0, 9);
                seg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                                      : $urandom_range(15, 45);
                cruise = $urandom_range(0, 380000) - 190000;
                for (int k = 0; k < seg_len; k++) begin
                    // pedal voltage shaped by segment kind
                    if (kind <= 3)
                        mv = $urandom_range(0, (th_list[p] > 0) ? th_list[p] - 1 : 0);
                    else if (kind <= 6)
                        mv = $urandom_range(th_list[p], 4095);
                    else if (kind <= 8)
                        mv = int'(th_list[p]) + $urandom_range(0, 120) - 60;
                    else
                        mv = $urandom & 32'hFFF;
                    if (mv < 0)
                        mv = 0;
                    if (mv > 4095)
                        mv = 4095;
                    // speed sample: cruise with noise, raw patterns, extremes
                    pick = $urandom_range(0, 9);
                    if (pick <= 4)
                        rpm = cruise + $urandom_range(0, 2000) - 1000;
                    else if (pick <= 6)
                        rpm = $urandom;
                    else if (pick == 7)
                        rpm = $urandom_range(0, 400000) - 200000;
                    else if (pick == 8)
                        rpm = ($urandom_range(0, 1) == 0) ? -200000 : 200000;
                    else
                        rpm = $urandom_range(0, 100) - 50;
                    send_sample(MV_W'(mv), RPM_W'(rpm));
                    sent++;
                end
                if ($urandom_range(0, 14) == 0)
                    wait_results_done();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_sensor_mv = '0;
        i_motor_rpm = '0;
        stall_on = 1'b1;
        idle_on = 1'b1;
        mismatch_count = 0;
        // model reset
        foreach (volt_ring[k]) volt_ring[k] = '0;
        foreach (rpm_ring[k]) rpm_ring[k] = '0;
        volt_slot = 0;
        rpm_slot = 0;
        volt_sum = '0;
        rpm_sum = '0;
        model_pressed = 1'b0;
        press_thresh = sdsh_pkg::THRESH_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_early_ticks();
        test_threshold_extremes();
        test_random_pedal();
        wait_results_done();

        if (pending_actions.size() != 0)
            report_mismatch("results left over", 0, pending_actions.size());
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
